>>> hdl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and helpers for the barometric compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned DIV_W  = 32;  // quotient bits, one per divider stage
  localparam int unsigned SIDE_W = 64;  // sideband carried through a divider
  localparam int unsigned ADDR_W = 5;   // 64-bit registers at 8-byte spacing
  localparam int unsigned DATA_W = 64;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_POFS = 2'd0;
  localparam logic [1:0] REG_PSNS = 2'd1;
  localparam logic [1:0] REG_TEMP = 2'd2;
  localparam logic [1:0] REG_OSS  = 2'd3;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] P_SCALE   = 32'd50000;
  localparam logic [31:0] P_BIAS    = 32'd32768;
  localparam logic [31:0] T_ROUND   = 32'd8;
  localparam logic [31:0] PC_SQ     = 32'd3038;
  localparam logic [31:0] PC_LIN    = 32'hFFFF_E343;  // -7357 as a 32-bit word
  localparam logic [31:0] PC_OFS    = 32'd3791;

  localparam int signed P_MIN = -1048576;
  localparam int signed P_MAX = 1048575;
  localparam int signed T_MIN = -32768;
  localparam int signed T_MAX = 32767;

  // Calibration words, each extended to the 32-bit working width.
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] b2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] b1;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] mc;
    logic [31:0] md;
    logic [1:0]  oss;
  } bsc_coef_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    return 32'($signed(v) >>> s);
  endfunction

endpackage

>>> hdl/bsc_cfg.sv
// ----------------------------------------------------------------------------
// bsc_cfg
// Register file for the calibration coefficients and oversampling setting.
// ----------------------------------------------------------------------------
module bsc_cfg import bsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output bsc_coef_t         coef
);

  logic [47:0] pofs_r;
  logic [47:0] psns_r;
  logic [63:0] tcoef_r;
  logic [1:0]  oss_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pofs_r  <= '0;
      psns_r  <= '0;
      tcoef_r <= '0;
      oss_r   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POFS: pofs_r  <= pwdata[47:0];
        REG_PSNS: psns_r  <= pwdata[47:0];
        REG_TEMP: tcoef_r <= pwdata;
        REG_OSS:  oss_r   <= pwdata[1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POFS: prdata = {16'd0, pofs_r};
      REG_PSNS: prdata = {16'd0, psns_r};
      REG_TEMP: prdata = tcoef_r;
      REG_OSS:  prdata = {62'd0, oss_r};
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    coef.ac1 = sx16(pofs_r[47:32]);
    coef.ac2 = sx16(pofs_r[31:16]);
    coef.b2  = sx16(pofs_r[15:0]);
    coef.ac3 = sx16(psns_r[47:32]);
    coef.ac4 = {16'd0, psns_r[31:16]};
    coef.b1  = sx16(psns_r[15:0]);
    coef.ac5 = {16'd0, tcoef_r[63:48]};
    coef.ac6 = {16'd0, tcoef_r[47:32]};
    coef.mc  = sx16(tcoef_r[31:16]);
    coef.md  = sx16(tcoef_r[15:0]);
    coef.oss = oss_r;
  end

endmodule

>>> hdl/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsc_div import bsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [31:0]       in_num,
  input  logic [31:0]       in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [31:0]       out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [DIV_W];
  logic [31:0]       rem_r  [DIV_W];
  logic [31:0]       num_r  [DIV_W];
  logic [31:0]       den_r  [DIV_W];
  logic [31:0]       quo_r  [DIV_W];
  logic [SIDE_W-1:0] side_r [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic              vld_i;
    logic [31:0]       rem_i;
    logic [31:0]       num_i;
    logic [31:0]       den_i;
    logic [31:0]       quo_i;
    logic [SIDE_W-1:0] side_i;
    logic [32:0]       trial;
    logic              ge;
    logic [31:0]       rem_nxt;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign num_i  = in_num;
      assign den_i  = in_den;
      assign quo_i  = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign num_i  = num_r[k-1];
      assign den_i  = den_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign trial   = {rem_i, num_i[31]};
    assign ge      = trial >= {1'b0, den_i};
    assign rem_nxt = ge ? 32'(trial - {1'b0, den_i}) : trial[31:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        num_r[k]  <= {num_i[30:0], 1'b0};
        den_r[k]  <= den_i;
        quo_r[k]  <= {quo_i[30:0], ge};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_vld  = vld_r[DIV_W-1];
  assign out_quo  = quo_r[DIV_W-1];
  assign out_side = side_r[DIV_W-1];

  // The caller substitutes a divisor of one for a zero divisor.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> in_den != 32'd0)
    else $error("divider fed a zero divisor");

  // A finished division always leaves a remainder below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DIV_W-1] |-> rem_r[DIV_W-1] < den_r[DIV_W-1])
    else $error("divider remainder not below divisor");

endmodule

>>> hdl/baro_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_top
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// Usage: write the calibration coefficients and oversampling setting through
// the APB-style port (64-bit registers at byte addresses 0, 8, 16 and 24)
// while the pipeline is empty, then present raw samples on the input channel.
// An input beat carries one raw temperature and one raw pressure word and is
// taken at a rising edge where in_valid is high and in_stall is low. Each beat
// yields exactly one output beat with the temperature in 0.1 C, the pressure
// in pascal and a status bit that flags a zero divisor (results then zero).
// Throughput is one beat per clock while the output is not stalled. A beat
// passes through 77 register stages, of which the two 32-stage dividers
// (one quotient bit per stage) make up most of the depth.
// The whole pipeline advances as one; when the receiver stalls a valid output
// beat, every stage holds and in_stall is raised in the same cycle, so no
// beat is lost or repeated. Reset clears all valid bits but not the data.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_top import bsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_raw_temperature,
  input  logic [18:0]       in_raw_pressure,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [15:0] out_temperature_decidegrees,
  output logic signed [20:0] out_pressure_pascal,
  output logic              out_status
);

  bsc_coef_t coef;
  logic      adv;

  bsc_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .coef
  );

  // Output register holds while a valid beat is stalled; all stages follow.
  logic out_valid_r;
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;

  // Stage 0: input register.
  logic        s0_vld_r;
  logic [15:0] s0_ut_r;
  logic [18:0] s0_up_r;

  // Stage 1: (UT - AC6) * AC5.
  logic        s1_vld_r;
  logic [31:0] s1_prod_r;
  logic [18:0] s1_up_r;

  // Stage 2: X1, divisor and operand magnitudes for the temperature division.
  logic        s2_vld_r;
  logic [31:0] s2_x1_r;
  logic [31:0] s2_an_r;
  logic [31:0] s2_ad_r;
  logic        s2_neg_r;
  logic        s2_flt_r;
  logic [18:0] s2_up_r;
  logic [31:0] s2_x1_nxt;
  logic [31:0] s2_div_nxt;
  logic [31:0] s2_num_nxt;

  // Temperature divider outputs.
  logic              da_vld;
  logic [31:0]       da_quo;
  logic [SIDE_W-1:0] da_side;
  logic [31:0]       da_x1;
  logic              da_neg;
  logic              da_flt;
  logic [18:0]       da_up;

  // Stage 3: B5 and the saturated temperature.
  logic        s3_vld_r;
  logic [31:0] s3_b5_r;
  logic [15:0] s3_t_r;
  logic        s3_flt_r;
  logic [18:0] s3_up_r;
  logic [31:0] s3_x2_nxt;
  logic [31:0] s3_b5_nxt;
  logic [31:0] s3_tw_nxt;

  // Stage 4: B6 and B6 squared.
  logic        s4_vld_r;
  logic [31:0] s4_b6_r;
  logic [31:0] s4_sqp_r;
  logic [15:0] s4_t_r;
  logic        s4_flt_r;
  logic [18:0] s4_up_r;
  logic [31:0] s4_b6_nxt;

  // Stage 5: the four coefficient products.
  logic        s5_vld_r;
  logic [31:0] s5_m1_r;
  logic [31:0] s5_m2_r;
  logic [31:0] s5_m3_r;
  logic [31:0] s5_m4_r;
  logic [15:0] s5_t_r;
  logic        s5_flt_r;
  logic [18:0] s5_up_r;
  logic [31:0] s5_sq_nxt;

  // Stage 6: B3 and the biased X3 that scales AC4.
  logic        s6_vld_r;
  logic [31:0] s6_b3_r;
  logic [31:0] s6_tb_r;
  logic [15:0] s6_t_r;
  logic        s6_flt_r;
  logic [18:0] s6_up_r;
  logic [31:0] s6_x3a_nxt;
  logic [31:0] s6_ofs_nxt;
  logic [31:0] s6_x3b_nxt;

  // Stage 7: B4 and UP - B3.
  logic        s7_vld_r;
  logic [31:0] s7_b4_r;
  logic [31:0] s7_dif_r;
  logic [15:0] s7_t_r;
  logic        s7_flt_r;
  logic [31:0] s7_b4p_nxt;

  // Stage 8: B7 and the pressure divisor.
  logic        s8_vld_r;
  logic [31:0] s8_b7_r;
  logic [31:0] s8_den_r;
  logic [15:0] s8_t_r;
  logic        s8_flt_r;
  logic [31:0] s8_scl_nxt;

  // Pressure divider outputs.
  logic              db_vld;
  logic [31:0]       db_quo;
  logic [SIDE_W-1:0] db_side;
  logic [31:0]       db_num;

  // Stage 9: P from the chosen division branch.
  logic        s9_vld_r;
  logic [31:0] s9_p_r;
  logic [15:0] s9_t_r;
  logic        s9_flt_r;

  // Stage 10: correction products.
  logic        s10_vld_r;
  logic [31:0] s10_sq_r;
  logic [31:0] s10_lin_r;
  logic [31:0] s10_p_r;
  logic [15:0] s10_t_r;
  logic        s10_flt_r;
  logic [31:0] s10_a_nxt;

  // Stage 11: shifted correction terms.
  logic        s11_vld_r;
  logic [31:0] s11_x1_r;
  logic [31:0] s11_x2_r;
  logic [31:0] s11_p_r;
  logic [15:0] s11_t_r;
  logic        s11_flt_r;
  logic [31:0] s11_sq3_nxt;

  // Output stage.
  logic [31:0] o_p_nxt;
  logic [31:0] o_corr_nxt;
  logic [20:0] o_ps_nxt;

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      s6_vld_r    <= 1'b0;
      s7_vld_r    <= 1'b0;
      s8_vld_r    <= 1'b0;
      s9_vld_r    <= 1'b0;
      s10_vld_r   <= 1'b0;
      s11_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r    <= in_valid;
      s1_vld_r    <= s0_vld_r;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= da_vld;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      s6_vld_r    <= s5_vld_r;
      s7_vld_r    <= s6_vld_r;
      s8_vld_r    <= s7_vld_r;
      s9_vld_r    <= db_vld;
      s10_vld_r   <= s9_vld_r;
      s11_vld_r   <= s10_vld_r;
      out_valid_r <= s11_vld_r;
    end
  end

  // ------------------------------------------------ temperature front end
  // X1 = (UT - AC6) * AC5 >> 15, and the divisor of X2 is X1 + MD. A zero
  // divisor is flagged and replaced by one so the divider stays defined.
  assign s2_x1_nxt  = asr32(s1_prod_r, 5'd15);
  assign s2_div_nxt = s2_x1_nxt + coef.md;
  assign s2_num_nxt = {coef.mc[20:0], 11'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ut_r   <= in_raw_temperature;
      s0_up_r   <= in_raw_pressure;
      s1_prod_r <= 32'(({16'd0, s0_ut_r} - coef.ac6) * coef.ac5);
      s1_up_r   <= s0_up_r;
      s2_x1_r   <= s2_x1_nxt;
      s2_an_r   <= s2_num_nxt[31] ? 32'(-s2_num_nxt) : s2_num_nxt;
      s2_ad_r   <= (s2_div_nxt == 32'd0) ? 32'd1 :
                   (s2_div_nxt[31] ? 32'(-s2_div_nxt) : s2_div_nxt);
      s2_neg_r  <= s2_num_nxt[31] ^ s2_div_nxt[31];
      s2_flt_r  <= (s2_div_nxt == 32'd0);
      s2_up_r   <= s1_up_r;
    end
  end

  bsc_div u_div_t (
    .clk, .rst_n, .en(adv),
    .in_vld  (s2_vld_r),
    .in_num  (s2_an_r),
    .in_den  (s2_ad_r),
    .in_side ({11'd0, s2_x1_r, s2_neg_r, s2_flt_r, s2_up_r}),
    .out_vld (da_vld),
    .out_quo (da_quo),
    .out_side(da_side)
  );

  assign da_x1  = da_side[52:21];
  assign da_neg = da_side[20];
  assign da_flt = da_side[19];
  assign da_up  = da_side[18:0];

  // ------------------------------------------ temperature and pressure core
  // The signed quotient truncates toward zero: divide magnitudes, then
  // restore the sign.
  assign s3_x2_nxt  = da_neg ? 32'(-da_quo) : da_quo;
  assign s3_b5_nxt  = da_x1 + s3_x2_nxt;
  assign s3_tw_nxt  = asr32(s3_b5_nxt + T_ROUND, 5'd4);
  assign s4_b6_nxt  = s3_b5_r - B6_OFFSET;
  assign s5_sq_nxt  = asr32(s4_sqp_r, 5'd12);
  assign s6_x3a_nxt = asr32(s5_m1_r, 5'd11) + asr32(s5_m2_r, 5'd11);
  assign s6_ofs_nxt = 32'(({coef.ac1[29:0], 2'b00} + s6_x3a_nxt) << coef.oss);
  assign s6_x3b_nxt = asr32(asr32(s5_m3_r, 5'd13) + asr32(s5_m4_r, 5'd16) + 32'd2,
                            5'd2);
  assign s7_b4p_nxt = 32'(coef.ac4 * s6_tb_r);
  assign s8_scl_nxt = P_SCALE >> coef.oss;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_b5_r  <= s3_b5_nxt;
      if ($signed(s3_tw_nxt) < T_MIN) begin
        s3_t_r <= 16'h8000;
      end else if ($signed(s3_tw_nxt) > T_MAX) begin
        s3_t_r <= 16'h7FFF;
      end else begin
        s3_t_r <= s3_tw_nxt[15:0];
      end
      s3_flt_r <= da_flt;
      s3_up_r  <= da_up;

      s4_b6_r  <= s4_b6_nxt;
      s4_sqp_r <= 32'(s4_b6_nxt * s4_b6_nxt);
      s4_t_r   <= s3_t_r;
      s4_flt_r <= s3_flt_r;
      s4_up_r  <= s3_up_r;

      s5_m1_r  <= 32'(coef.b2 * s5_sq_nxt);
      s5_m2_r  <= 32'(coef.ac2 * s4_b6_r);
      s5_m3_r  <= 32'(coef.ac3 * s4_b6_r);
      s5_m4_r  <= 32'(coef.b1 * s5_sq_nxt);
      s5_t_r   <= s4_t_r;
      s5_flt_r <= s4_flt_r;
      s5_up_r  <= s4_up_r;

      s6_b3_r  <= asr32(s6_ofs_nxt + 32'd2, 5'd2);
      s6_tb_r  <= s6_x3b_nxt + P_BIAS;
      s6_t_r   <= s5_t_r;
      s6_flt_r <= s5_flt_r;
      s6_up_r  <= s5_up_r;

      s7_b4_r  <= s7_b4p_nxt >> 15;
      s7_dif_r <= {13'd0, s6_up_r} - s6_b3_r;
      s7_t_r   <= s6_t_r;
      s7_flt_r <= s6_flt_r;

      s8_b7_r  <= 32'(s7_dif_r * s8_scl_nxt);
      s8_den_r <= (s7_b4_r == 32'd0) ? 32'd1 : s7_b4_r;
      s8_t_r   <= s7_t_r;
      s8_flt_r <= s7_flt_r || (s7_b4_r == 32'd0);
    end
  end

  // -------------------------------------------------------- pressure divide
  // Below 2^31 the doubled B7 fits and is divided; above, B7 is divided and
  // the quotient doubled.
  assign db_num = s8_b7_r[31] ? s8_b7_r : {s8_b7_r[30:0], 1'b0};

  bsc_div u_div_p (
    .clk, .rst_n, .en(adv),
    .in_vld  (s8_vld_r),
    .in_num  (db_num),
    .in_den  (s8_den_r),
    .in_side ({46'd0, s8_t_r, s8_flt_r, s8_b7_r[31]}),
    .out_vld (db_vld),
    .out_quo (db_quo),
    .out_side(db_side)
  );

  // ------------------------------------------------------ pressure polish
  assign s10_a_nxt   = asr32(s9_p_r, 5'd8);
  assign s11_sq3_nxt = 32'(s10_sq_r * PC_SQ);
  assign o_corr_nxt  = asr32(s11_x1_r + s11_x2_r + PC_OFS, 5'd4);
  assign o_p_nxt     = s11_p_r + o_corr_nxt;

  always_comb begin
    if ($signed(o_p_nxt) < P_MIN) begin
      o_ps_nxt = 21'h10_0000;
    end else if ($signed(o_p_nxt) > P_MAX) begin
      o_ps_nxt = 21'h0F_FFFF;
    end else begin
      o_ps_nxt = o_p_nxt[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_p_r    <= db_side[0] ? {db_quo[30:0], 1'b0} : db_quo;
      s9_t_r    <= db_side[17:2];
      s9_flt_r  <= db_side[1];

      s10_sq_r  <= 32'(s10_a_nxt * s10_a_nxt);
      s10_lin_r <= 32'(PC_LIN * s9_p_r);
      s10_p_r   <= s9_p_r;
      s10_t_r   <= s9_t_r;
      s10_flt_r <= s9_flt_r;

      s11_x1_r  <= asr32(s11_sq3_nxt, 5'd16);
      s11_x2_r  <= asr32(s10_lin_r, 5'd16);
      s11_p_r   <= s10_p_r;
      s11_t_r   <= s10_t_r;
      s11_flt_r <= s10_flt_r;

      // A zero divisor anywhere forces both results to zero.
      out_status                  <= s11_flt_r;
      out_temperature_decidegrees <= s11_flt_r ? 16'sd0 : $signed(s11_t_r);
      out_pressure_pascal         <= s11_flt_r ? 21'sd0 : $signed(o_ps_nxt);
    end
  end

  // Stalls come only from a held output beat.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid_r && out_stall))
    else $error("input stall not tied to a held output beat");

  // A faulted beat carries zero results.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status) |->
      (out_temperature_decidegrees == 16'sd0 && out_pressure_pascal == 21'sd0))
    else $error("faulted beat carries nonzero results");

  // A beat in the last stage reaches the output register on the next advance.
  a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s11_vld_r) |=> out_valid_r)
    else $error("beat dropped at the output register");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives raw temperature and pressure beats through the compensation block
// under several calibration sets. A scoreboard recomputes each result in
// wrapping 32-bit arithmetic and compares it with every output beat in order.
// ----------------------------------------------------------------------------
module testbench;
  import bsc_pkg::*;

  localparam int unsigned LATENCY = 76;
  localparam int unsigned N_RANDOM = 1650;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic signed [20:0] pressure;
    logic               status;
  } comp_result_t;

  // Scoreboard: holds its own copy of the calibration and a queue of the
  // results that the accepted beats should produce.
  class comp_scoreboard;
    logic [47:0] ofs_coeffs;
    logic [47:0] sense_coeffs;
    logic [63:0] temp_coeffs;
    logic [1:0]  oss;
    comp_result_t pending[$];
    int errors;

    function new();
      ofs_coeffs = '0;
      sense_coeffs = '0;
      temp_coeffs = '0;
      oss = '0;
      errors = 0;
    endfunction

    function automatic logic [31:0] sext(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(logic [31:0] v, int s);
      return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] quot_trunc(logic [31:0] n, logic [31:0] d);
      logic [31:0] an, ad, q;
      an = n[31] ? -n : n;
      ad = d[31] ? -d : d;
      q = an / ad;
      return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic comp_result_t compensate(logic [15:0] ut16, logic [18:0] up19);
      logic [31:0] ac1, ac2, b2, ac3, ac4, b1, ac5, ac6, mc, md, ut, up;
      logic [31:0] x1, x2, x3, dv, b5, b6, b3, b4, b7, p, sq, t;
      comp_result_t r;
      ac1 = sext(ofs_coeffs[47:32]);
      ac2 = sext(ofs_coeffs[31:16]);
      b2  = sext(ofs_coeffs[15:0]);
      ac3 = sext(sense_coeffs[47:32]);
      ac4 = {16'd0, sense_coeffs[31:16]};
      b1  = sext(sense_coeffs[15:0]);
      ac5 = {16'd0, temp_coeffs[63:48]};
      ac6 = {16'd0, temp_coeffs[47:32]};
      mc  = sext(temp_coeffs[31:16]);
      md  = sext(temp_coeffs[15:0]);
      ut = {16'd0, ut16};
      up = {13'd0, up19};
      r = '{temperature: '0, pressure: '0, status: 1'b1};
      x1 = sra((ut - ac6) * ac5, 15);
      dv = x1 + md;
      if (dv == 0) return r;
      x2 = quot_trunc(mc << 11, dv);
      b5 = x1 + x2;
      t = sra(b5 + 32'd8, 4);
      b6 = b5 - 32'd4000;
      sq = sra(b6 * b6, 12);
      x1 = sra(b2 * sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sra((((ac1 << 2) + x3) << oss) + 32'd2, 2);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) return r;
      b7 = (up - b3) * (32'd50000 >> oss);
      if (!b7[31]) p = (b7 << 1) / b4;
      else p = (b7 / b4) << 1;
      x1 = sra(p, 8) * sra(p, 8);
      x1 = sra(x1 * 32'd3038, 16);
      x2 = sra(32'hFFFF_E343 * p, 16);
      p = p + sra(x1 + x2 + 32'd3791, 4);
      if ($signed(t) < T_MIN) r.temperature = 16'sh8000;
      else if ($signed(t) > T_MAX) r.temperature = 16'sh7FFF;
      else r.temperature = t[15:0];
      if ($signed(p) < P_MIN) r.pressure = 21'h100000;
      else if ($signed(p) > P_MAX) r.pressure = 21'h0FFFFF;
      else r.pressure = p[20:0];
      r.status = 1'b0;
      return r;
    endfunction

    function void note_sample(logic [15:0] ut, logic [18:0] up);
      pending.push_back(compensate(ut, up));
    endfunction

    task check_result(comp_result_t got);
      comp_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("output beat with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.temperature !== want.temperature)
        report_mismatch($sformatf("temperature %0d, expected %0d",
                                  got.temperature, want.temperature));
      if (got.pressure !== want.pressure)
        report_mismatch($sformatf("pressure %0d, expected %0d",
                                  got.pressure, want.pressure));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0b, expected %0b", got.status, want.status));
    endtask

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_raw_temperature = '0;
  logic [18:0] in_raw_pressure = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_temperature_decidegrees;
  logic signed [20:0] out_pressure_pascal;
  logic out_status;

  comp_scoreboard sb = new();
  longint unsigned cycles = 0;

  baro_sensor_compensation_top dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: the pipeline never needs anywhere near this many cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: every accepted beat goes to the scoreboard. The stall is
  // drawn per beat, sometimes held off entirely for long stretches.
  int stall_left = 0;
  bit calm_phase = 1'b0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{temperature: out_temperature_decidegrees,
                        pressure: out_pressure_pascal, status: out_status});
    if (rst_n && out_valid && !out_stall) begin
      if (calm_phase) stall_left = 0;
      else stall_left = ($urandom_range(3) == 0) ? $urandom_range(16) : 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One register write: a setup phase, then an access phase.
  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POFS: sb.ofs_coeffs = value[47:0];
      REG_PSNS: sb.sense_coeffs = value[47:0];
      REG_TEMP: sb.temp_coeffs = value;
      default:  sb.oss = value[1:0];
    endcase
  endtask

  // Loads a whole calibration set once the pipeline has emptied.
  task automatic load_calibration(logic [47:0] pofs, logic [47:0] psns,
                                  logic [63:0] tco, logic [1:0] oss);
    wait_idle();
    write_reg(REG_POFS, {16'd0, pofs});
    write_reg(REG_PSNS, {16'd0, psns});
    write_reg(REG_TEMP, tco);
    write_reg(REG_OSS, {62'd0, oss});
  endtask

  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Sends one sample beat, after a random gap unless no_gap is set; valid stays up across
  // back-to-back beats without being dropped in between.
  task automatic send_sample(logic [15:0] ut, logic [18:0] up, bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(2) == 0) ? $urandom_range(16) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_temperature <= ut;
    in_raw_pressure <= up;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(ut, up);
  endtask

  task automatic finish_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Typical factory calibration, used as a base for plausible random sets.
  localparam logic [47:0] STD_POFS = {16'sd408, -16'sd72, 16'sd4};
  localparam logic [47:0] STD_PSNS = {-16'sd14383, 16'd32741, 16'sd6190};
  localparam logic [63:0] STD_TCO  = {16'd32757, 16'd23153, -16'sd8711, 16'sd2868};

  function automatic logic [15:0] jitter16(logic [15:0] v);
    return v + 16'($urandom_range(64)) - 16'd32;
  endfunction

  initial begin
    logic [15:0] ut;
    logic [18:0] up;
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: defaults give a zero temperature divisor.
    send_sample(16'd0, 19'd0, 1'b1);
    send_sample(16'hFFFF, 19'h7FFFF, 1'b1);
    finish_burst();

    // Datasheet example set and field extremes.
    load_calibration(STD_POFS, STD_PSNS, STD_TCO, 2'd0);
    send_sample(16'd27898, 19'd23843, 1'b1);
    send_sample(16'd0, 19'd0, 1'b1);
    send_sample(16'hFFFF, 19'h7FFFF, 1'b1);
    send_sample(16'hFFFF, 19'd0, 1'b0);
    send_sample(16'd0, 19'h7FFFF, 1'b0);
    send_sample(16'h5555, 19'h2AAAA, 1'b0);
    send_sample(16'hAAAA, 19'h55555, 1'b1);
    finish_burst();

    // Largest oversampling with full-scale coefficients.
    load_calibration(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3);
    send_sample(16'd0, 19'd0, 1'b1);
    send_sample(16'hFFFF, 19'h7FFFF, 1'b1);
    send_sample(16'h8000, 19'h40000, 1'b1);
    finish_burst();

    // Zero pressure divisor: AC4 of zero forces B4 to zero.
    load_calibration(STD_POFS, {16'h8000, 16'd0, 16'h7FFF}, STD_TCO, 2'd1);
    send_sample(16'd27898, 19'd23843, 1'b1);
    send_sample(16'd1000, 19'd100, 1'b1);
    finish_burst();

    // Zero temperature divisor with X1 and MD both zero (UT equal to AC6).
    load_calibration({16'h7FFF, 16'h8000, 16'h8000}, {16'h7FFF, 16'hFFFF, 16'h8000},
                     {16'd1, 16'd500, 16'h7FFF, 16'd0}, 2'd2);
    send_sample(16'd500, 19'd1234, 1'b1);
    send_sample(16'd501, 19'd1234, 1'b1);
    send_sample(16'd499, 19'h7FFFF, 1'b1);
    finish_burst();

    // Random phases: mostly plausible calibrations near the typical set,
    // some fully random ones to hit saturation and the division branches.
    for (phase = 0; phase < 11; phase++) begin
      logic [47:0] pofs, psns;
      logic [63:0] tco;
      if (phase % 3 == 2) begin
        pofs = {$urandom, $urandom};
        psns = {$urandom, $urandom};
        tco = {$urandom, $urandom};
      end else begin
        pofs = {jitter16(STD_POFS[47:32]), jitter16(STD_POFS[31:16]),
                jitter16(STD_POFS[15:0])};
        psns = {jitter16(STD_PSNS[47:32]), jitter16(STD_PSNS[31:16]),
                jitter16(STD_PSNS[15:0])};
        tco = {jitter16(STD_TCO[63:48]), jitter16(STD_TCO[47:32]),
               jitter16(STD_TCO[31:16]), jitter16(STD_TCO[15:0])};
      end
      load_calibration(pofs, psns, tco, 2'($urandom_range(3)));
      calm_phase = (phase == 4);
      for (int i = 0; i < N_RANDOM / 11; i++) begin
        if ($urandom_range(3) != 0) begin
          ut = 16'($urandom_range(20000, 40000));
          up = 19'($urandom_range(10000, 100000 << sb.oss) & 19'h7FFFF);
        end else begin
          ut = 16'($urandom);
          up = 19'($urandom);
        end
        send_sample(ut, up, calm_phase);
      end
      finish_burst();
    end
    calm_phase = 1'b0;

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
